// ----- sv/dpyr_pkg.sv -----
// types and constants shared by the downsampling pyramid modules
`timescale 1ns / 1ps

package dpyr_pkg;

  localparam int VAL_W     = 24;
  localparam int IDX_W     = 6;
  localparam int LVL_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = val_t'(24'sh7FFFFF);
  localparam val_t VAL_MIN = val_t'(24'sh800000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE = 1'b1;

  // combine modes
  localparam logic MODE_AVG = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef struct packed {
    logic mode;
    val_t held;
    val_t value;
    val_t cur_min;
    val_t cur_max;
  } alu_in_t;

  typedef struct packed {
    val_t combined;
    val_t new_min;
    val_t new_max;
  } alu_out_t;

endpackage

// ----- sv/dpyr_alu.sv -----
// shared combine and running min/max unit, used once per level step
`timescale 1ns / 1ps

module dpyr_alu (
  input  dpyr_pkg::alu_in_t  op_i,
  output dpyr_pkg::alu_out_t res_o
);
  import dpyr_pkg::*;

  logic signed [VAL_W:0] sum;
  val_t                  avg;
  val_t                  larger;

  // floor of the pair average: arithmetic shift of the 25-bit sum
  assign sum    = {op_i.held[VAL_W-1], op_i.held} + {op_i.value[VAL_W-1], op_i.value};
  assign avg    = sum[VAL_W:1];
  assign larger = (op_i.held > op_i.value) ? op_i.held : op_i.value;

  always_comb begin
    res_o.combined = (op_i.mode == MODE_MAX) ? larger : avg;
    res_o.new_min  = (op_i.value < op_i.cur_min) ? op_i.value : op_i.cur_min;
    res_o.new_max  = (op_i.value > op_i.cur_max) ? op_i.value : op_i.cur_max;
  end

endmodule

// ----- sv/dyadic_downsample_pyramid.sv -----
// top level: sequencer, held-pair and min/max memories, output register
`timescale 1ns / 1ps

// Dyadic downsampling pyramid. Each input beat is one point of a sample vector; the
// block emits one output beat per pyramid level that the point reaches, level 0 first,
// with last set on the final one. A point reaches level k+1 when it completes a pair
// at level k (k below the configured depth). The input is taken in the idle state, then
// every level reached passes through a read state, for the held-pair and min/max
// memories, and an evaluate state in the shared combine unit, which waits while the
// output is stalled. The input is not ready while an item is in progress. After reset
// the block sweeps its held-pair memory once, also resetting the min/max memory, before
// taking the first item; configuration writes are taken throughout.
module dyadic_downsample_pyramid #(
  parameter int POINTS = 64,
  parameter int LEVELS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dpyr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dpyr_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dpyr_pkg::VAL_W-1:0]   sample_value_i,
  input  logic [dpyr_pkg::IDX_W-1:0]          point_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dpyr_pkg::LVL_W-1:0]          level_o,
  output logic [dpyr_pkg::IDX_W-1:0]          point_index_out_o,
  output logic signed [dpyr_pkg::VAL_W-1:0]   level_value_o,
  output logic signed [dpyr_pkg::VAL_W-1:0]   level_minimum_o,
  output logic signed [dpyr_pkg::VAL_W-1:0]   level_maximum_o,
  output logic                                last_o
);
  import dpyr_pkg::*;

  localparam int SLOTS  = LEVELS * POINTS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PT_W   = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int MM_W   = $clog2(LEVELS);
  localparam int IDX_N  = 1 << IDX_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   LEVELS_X  = (SLOT_W + 1)'(LEVELS);
  localparam logic [LVL_W:0]    TOP_LVL   = (LVL_W + 1)'(LEVELS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL} state_e;

  // raw index folded onto the stored points
  function automatic logic [PT_W-1:0] point_slot(input logic [IDX_W-1:0] raw);
    logic [PT_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_N; i++) begin
      if (raw == IDX_W'(i)) r = PT_W'(i % POINTS);
    end
    return r;
  endfunction

  state_e               state_q;
  logic [SLOT_W-1:0]    clr_q;
  logic                 mode_q;
  logic [LVL_W-1:0]     depth_cfg_q;
  logic [LVL_W-1:0]     depth_eff;
  val_t                 v_q;
  logic [IDX_W-1:0]     idx_q;
  logic [PT_W-1:0]      p_q;
  logic [LVL_W-1:0]     lvl_q;

  logic                 out_valid_q;
  logic [LVL_W-1:0]     out_level_q;
  logic [IDX_W-1:0]     out_idx_q;
  val_t                 out_value_q;
  val_t                 out_min_q;
  val_t                 out_max_q;
  logic                 out_last_q;

  // held-pair memory: {flag, value}; min/max memory: {min, max}
  logic [VAL_W:0]       held_mem [SLOTS];
  logic [2*VAL_W-1:0]   mm_mem   [LEVELS];
  logic [VAL_W:0]       held_rd_q;
  logic [2*VAL_W-1:0]   mm_rd_q;

  logic [SLOT_W-1:0]    slot;
  logic [MM_W-1:0]      mm_idx;
  logic                 held_we;
  logic [SLOT_W-1:0]    held_wa;
  logic [VAL_W:0]       held_wd;
  logic                 mm_we;
  logic [MM_W-1:0]      mm_wa;
  logic [2*VAL_W-1:0]   mm_wd;

  logic                 in_fire;
  logic                 eval_go;
  logic                 pairing;
  logic                 more;
  alu_in_t              alu_op;
  alu_out_t             alu_res;

  assign depth_eff = ({1'b0, depth_cfg_q} > TOP_LVL) ? TOP_LVL[LVL_W-1:0] : depth_cfg_q;
  assign slot      = SLOT_W'(lvl_q) * SLOT_W'(POINTS) + SLOT_W'(p_q);
  assign mm_idx    = MM_W'(lvl_q);
  assign in_fire   = in_valid_i && in_ready_o;
  assign eval_go   = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);
  assign pairing   = lvl_q < depth_eff;
  assign more      = pairing && held_rd_q[VAL_W];

  always_comb begin
    alu_op.mode    = mode_q;
    alu_op.held    = held_rd_q[VAL_W-1:0];
    alu_op.value   = v_q;
    alu_op.cur_min = mm_rd_q[2*VAL_W-1:VAL_W];
    alu_op.cur_max = mm_rd_q[VAL_W-1:0];
  end

  dpyr_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // memory write port: clearing sweep or level update
  always_comb begin
    held_we = 1'b0;
    held_wa = slot;
    held_wd = {1'b1, v_q};
    mm_we   = 1'b0;
    mm_wa   = mm_idx;
    mm_wd   = {alu_res.new_min, alu_res.new_max};
    if (state_q == ST_CLEAR) begin
      held_we = 1'b1;
      held_wa = clr_q;
      held_wd = '0;
      mm_we   = {1'b0, clr_q} < LEVELS_X;
      mm_wa   = MM_W'(clr_q);
      mm_wd   = {VAL_MAX, VAL_MIN};
    end else if (eval_go) begin
      mm_we   = 1'b1;
      held_we = pairing;
      // second of a pair frees the slot, first of a pair is held
      held_wd = held_rd_q[VAL_W] ? {1'b0, held_rd_q[VAL_W-1:0]} : {1'b1, v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) held_mem[held_wa] <= held_wd;
    if (mm_we) mm_mem[mm_wa] <= mm_wd;
    held_rd_q <= held_mem[slot];
    mm_rd_q   <= mm_mem[mm_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_AVG;
      depth_cfg_q <= LVL_W'(31);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COMBINE_MODE:  mode_q      <= cfg_data_i[0];
        REG_LEVELS_IN_USE: depth_cfg_q <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      v_q         <= '0;
      idx_q       <= '0;
      p_q         <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      out_level_q <= '0;
      out_idx_q   <= '0;
      out_value_q <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !eval_go) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_SLOT) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            v_q     <= sample_value_i;
            idx_q   <= point_index_i;
            p_q     <= point_slot(point_index_i);
            lvl_q   <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_go) begin
            out_valid_q <= 1'b1;
            out_level_q <= lvl_q;
            out_idx_q   <= idx_q;
            out_value_q <= v_q;
            out_min_q   <= alu_res.new_min;
            out_max_q   <= alu_res.new_max;
            out_last_q  <= !more;
            if (more) begin
              v_q     <= alu_res.combined;
              lvl_q   <= lvl_q + 1'b1;
              state_q <= ST_READ;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign level_o           = out_level_q;
  assign point_index_out_o = out_idx_q;
  assign level_value_o     = out_value_q;
  assign level_minimum_o   = out_min_q;
  assign level_maximum_o   = out_max_q;
  assign last_o            = out_last_q;

  // a level above the configured depth is never reported
  a_level_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= depth_cfg_q)
    else $error("output level above configured depth");

  // reported value lies within the running bounds of its level
  a_value_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_minimum_o <= level_value_o) && (level_value_o <= level_maximum_o))
    else $error("level value outside running min/max");

  // after a non-final beat the item is still being worked on or its next beat is out
  a_busy_after_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o || !in_ready_o)
    else $error("block idle before final beat of an item");

endmodule
